// ===== hw/rtl/sis_pkg.sv =====
package sis_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } sis_cmd_t;

endpackage

// ===== hw/rtl/sis_req_if.sv =====
interface sis_req_if import sis_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               operation;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [IDX_W-1:0]              position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

// ===== hw/rtl/sis_rsp_if.sv =====
interface sis_rsp_if import sis_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] result_value;
  logic [CNT_W-1:0]              entry_count;
  logic [STATUS_W-1:0]           status;

  modport source (output valid, output result_value, output entry_count,
                  output status, input ready);
  modport sink (input valid, input result_value, input entry_count, input status,
                output ready);
endinterface

// ===== hw/rtl/sis_datapath.sv =====
module sis_datapath import sis_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  sis_cmd_t                      cmd,
  input  logic [OP_W-1:0]               req_operation,
  input  logic signed [VALUE_WIDTH-1:0] req_value,
  input  logic [IDX_W-1:0]              req_position,
  output logic signed [VALUE_WIDTH-1:0] result_value,
  output logic [CNT_W-1:0]              entry_count,
  output logic [STATUS_W-1:0]           status
);

  op_t                          op;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [IDX_W-1:0]             pos;

  logic signed [VALUE_WIDTH-1:0] entries [DEPTH];
  logic signed [VALUE_WIDTH-1:0] entries_next [DEPTH];
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;

  logic [DEPTH-1:0]             ge;
  logic [DEPTH-1:0]             rm;
  logic [IDX_W-1:0]             rd_idx;
  logic                         full;
  logic                         empty;
  logic                         pos_ok;
  logic                         do_ins;
  logic                         do_rm;
  status_t                      status_next;
  logic signed [VALUE_WIDTH-1:0] result_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= op_t'(req_operation);
      value <= req_value;
      pos   <= req_position;
    end
  end

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign pos_ok = (CNT_W'(pos) < count);
  assign rd_idx = (op == OP_POP) ? IDX_W'(count - CNT_W'(1)) : pos;

  // ge marks every cell at or past the insert slot: stored values greater
  // than the new one and all unused cells. Sorted order keeps it a thermometer.
  // rm marks every cell at or past the removed entry.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) >= count) || (entries[i] > value);
      rm[i] = (CNT_W'(i) >= CNT_W'(rd_idx));
    end
  end

  always_comb begin
    status_next = ST_OK;
    result_next = '0;
    count_next  = count;
    do_ins      = 1'b0;
    do_rm       = 1'b0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          do_rm       = 1'b1;
          result_next = entries[rd_idx];
          count_next  = count - CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (!pos_ok) begin
          status_next = ST_BADPOS;
        end else begin
          do_rm       = 1'b1;
          result_next = entries[rd_idx];
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Each cell looks only at itself, its two neighbors and the new value.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
    end
    if (do_ins) begin
      if (ge[0]) begin
        entries_next[0] = value;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (ge[i]) begin
          entries_next[i] = ge[i-1] ? entries[i-1] : value;
        end
      end
    end else if (do_rm) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (rm[i]) begin
          entries_next[i] = entries[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
      result_value <= result_next;
      status       <= status_next;
      entry_count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

endmodule

// ===== hw/rtl/sis_ctrl.sv =====
module sis_ctrl import sis_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output sis_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_full || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (cmd.exec) begin
      out_full_next = 1'b1;
    end else if (rsp_ready) begin
      out_full_next = 1'b0;
    end
  end

  assign rsp_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

// ===== hw/rtl/sorted_insert_stack.sv =====
// Sorted store of up to DEPTH signed values, kept in ascending order in a row
// of register cells. Each transaction on req is an insert, a pop of the
// largest value or a removal at a position (0 is the smallest); other codes
// change nothing and report ok. Each yields exactly one transaction on rsp
// with the value taken out (zero for an insert or an error), the count
// afterwards and a status: ok, empty, full or bad position. An equal value is
// inserted after the ones already stored. A transaction first captures the
// request, then in the update step every cell compares against the new value
// and shifts in parallel. A request is accepted while a result still waits in
// the output register; the update step then holds until that result is taken.
module sorted_insert_stack import sis_pkg::*; (
  input logic   clk,
  input logic   rst,
  sis_req_if.sink   req,
  sis_rsp_if.source rsp
);

  sis_cmd_t cmd;

  sis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  sis_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_operation (req.operation),
    .req_value     (req.value),
    .req_position  (req.position),
    .result_value  (rsp.result_value),
    .entry_count   (rsp.entry_count),
    .status        (rsp.status)
  );

endmodule

// ===== hw/rtl/sis_checker.sv =====
module sis_checker import sis_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic signed [VALUE_WIDTH-1:0] rsp_result_value,
  input logic [CNT_W-1:0]              rsp_entry_count,
  input logic [STATUS_W-1:0]           rsp_status
);

  // A stalled result must hold its payload.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
      && $stable(rsp_entry_count) && $stable(rsp_status))
    else $error("result changed while stalled");

  // Only one request is processed at a time.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted during processing");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_result_value == '0)
    else $error("nonzero value with error status");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY) |->
      ((rsp_status == ST_FULL) == (rsp_entry_count == CNT_W'(DEPTH)))
      && ((rsp_status == ST_EMPTY) == (rsp_entry_count == '0)))
    else $error("full or empty status disagrees with count");

endmodule

bind sorted_insert_stack sis_checker u_sis_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_result_value (rsp.result_value),
  .rsp_entry_count  (rsp.entry_count),
  .rsp_status       (rsp.status)
);

// ===== dv/tb_sorted_insert_stack.sv =====
module tb_sorted_insert_stack import sis_pkg::*; ();

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam int CYCLE_LIMIT = 200000;

  // Shadow copy of the sorted store. Every accepted request is applied here
  // at once, and the result it must produce is queued in order.
  class sorted_store_scoreboard;
    typedef struct {
      logic signed [VALUE_WIDTH-1:0] result_value;
      logic [CNT_W-1:0]              entry_count;
      status_t                       status;
    } result_t;

    logic signed [VALUE_WIDTH-1:0] entries [DEPTH];
    int      fill;
    result_t pending_results[$];
    int      fail_count;

    function new();
      fill = 0;
      fail_count = 0;
    endfunction

    function int count();
      return fill;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic signed [VALUE_WIDTH-1:0] val,
                               logic [IDX_W-1:0] pos);
      result_t r;
      int      slot;
      r.result_value = '0;
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (fill == DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // Equal values go behind the ones already stored.
            slot = fill;
            for (int i = 0; i < fill; i++) begin
              if (entries[i] > val) begin
                slot = i;
                break;
              end
            end
            for (int i = fill; i > slot; i--) entries[i] = entries[i-1];
            entries[slot] = val;
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.result_value = entries[fill-1];
            fill--;
          end
        end
        OP_REMOVE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (int'(pos) >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            r.result_value = entries[pos];
            for (int i = int'(pos); i < fill - 1; i++) entries[i] = entries[i+1];
            fill--;
          end
        end
        default: ;
      endcase
      r.entry_count = CNT_W'(fill);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic signed [VALUE_WIDTH-1:0] got_value,
                               logic [CNT_W-1:0] got_count,
                               logic [STATUS_W-1:0] got_status);
      result_t want;
      if (pending_results.size() == 0) begin
        if (fail_count < 10)
          $display("mismatch: unexpected result value %0d count %0d status %0d",
                   got_value, got_count, got_status);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got_value !== want.result_value || got_count !== want.entry_count ||
          got_status !== want.status) begin
        if (fail_count < 10)
          $display("mismatch: value exp %0d got %0d, count exp %0d got %0d, status exp %s got %0d",
                   want.result_value, got_value, want.entry_count, got_count,
                   want.status.name(), got_status);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  bit   tx_idle;
  bit   rx_idle;
  int   rx_hold;

  sorted_store_scoreboard sb;

  sis_req_if req_ch();
  sis_rsp_if rsp_ch();

  sorted_insert_stack i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [VALUE_WIDTH-1:0] val,
                              input logic [IDX_W-1:0] pos);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.operation = op;
    req_ch.value     = val;
    req_ch.position  = pos;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, val, pos);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input int n, input int insert_pct);
    logic [OP_W-1:0]               op;
    logic signed [VALUE_WIDTH-1:0] val;
    logic [IDX_W-1:0]              pos;
    int                            r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) op = OP_INSERT;
      else if (r >= 96) op = OP_UNUSED;
      else op = $urandom_range(0, 1) ? OP_POP : OP_REMOVE;
      // Small values produce plenty of duplicates to exercise equal ordering.
      case ($urandom_range(0, 3))
        0: val = $signed($urandom_range(0, 8)) - 4;
        1: val = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        default: val = $urandom;
      endcase
      if (sb.count() > 0 && $urandom_range(0, 4) != 0)
        pos = IDX_W'($urandom_range(0, sb.count() - 1));
      else pos = IDX_W'($urandom_range(0, DEPTH - 1));
      send_request(op, val, pos);
    end
  endtask

  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      sb.check_result(rsp_ch.result_value, rsp_ch.entry_count, rsp_ch.status);
      @(negedge clk);
    end
  end

  initial begin
    sb = new();
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_INSERT;
    req_ch.value     = '0;
    req_ch.position  = '0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    rx_hold          = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty-store errors, unused op codes, extremes, duplicates, bad positions.
    send_request(OP_POP, VAL_MAX, '0);
    send_request(OP_REMOVE, '0, '0);
    send_request(OP_UNUSED, '1, '1);
    send_request(OP_INSERT, VAL_MAX, '0);
    send_request(OP_INSERT, VAL_MIN, '0);
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, -1, '0);
    send_request(OP_INSERT, 5, '1);
    send_request(OP_REMOVE, '0, 4'd15);
    send_request(OP_REMOVE, '0, 4'd6);
    send_request(OP_REMOVE, '0, 4'd0);
    send_request(OP_REMOVE, '0, 4'd1);
    send_request(OP_UNUSED, VAL_MIN, 4'd3);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);

    run_random(150, 55);
    wait_drained();

    // Receiver holds off for a long stretch while inserts keep coming, so the
    // block backs up; the excess inserts are refused once the store is full.
    rx_hold = 300;
    tx_idle = 1'b0;
    repeat (20) send_request(OP_INSERT, $urandom, IDX_W'($urandom_range(0, DEPTH - 1)));

    rx_idle = 1'b0;
    run_random(150, 40);
    tx_idle = 1'b1;
    run_random(150, 70);
    wait_drained();
    rx_idle = 1'b1;
    tx_idle = 1'b0;
    run_random(150, 30);
    tx_idle = 1'b1;
    run_random(130, 50);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sis_pkg.sv
hw/rtl/sis_req_if.sv
hw/rtl/sis_rsp_if.sv
hw/rtl/sis_datapath.sv
hw/rtl/sis_ctrl.sv
hw/rtl/sorted_insert_stack.sv
hw/rtl/sis_checker.sv
dv/tb_sorted_insert_stack.sv
